/* rtl/fhs_pkg.sv */
// ----------------------------------------------------------------------------
// fhs_pkg
// Shared types and widths for the first-fit hour-slot allocator.
// ----------------------------------------------------------------------------
package fhs_pkg;

  // Field widths of the request and response beats
  localparam int HOUR_W = 5;
  localparam int VEH_W  = 6;

  // Cell index width, wide enough for the largest supported vehicle count
  localparam int IDX_W  = 6;

  // Running count width, holds the largest vehicle number itself
  localparam int CNT_W  = 7;

  // Control half of the token that walks the cell chain
  typedef struct packed {
    logic             active;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } fhs_tok_t;

endpackage

/* rtl/fhs_if.sv */
// ----------------------------------------------------------------------------
// fhs_req_if / fhs_rsp_if
// Valid/ready channels for booking requests and grant responses.
// ----------------------------------------------------------------------------
interface fhs_req_if;
  import fhs_pkg::*;

  logic              valid;
  logic              ready;
  logic [HOUR_W-1:0] start_hour;
  logic [HOUR_W-1:0] end_hour;
  logic              new_batch;

  modport source (output valid, output start_hour, output end_hour, output new_batch,
                  input ready);
  modport sink   (input valid, input start_hour, input end_hour, input new_batch,
                  output ready);
endinterface

interface fhs_rsp_if;
  import fhs_pkg::*;

  logic             valid;
  logic             ready;
  logic [VEH_W-1:0] vehicle;
  logic [VEH_W-1:0] vehicles_in_use;
  logic             refused;

  modport source (output valid, output vehicle, output vehicles_in_use, output refused,
                  input ready);
  modport sink   (input valid, input vehicle, input vehicles_in_use, input refused,
                  output ready);
endinterface

/* rtl/first_fit_hour_slot_allocator_core.sv */
// ----------------------------------------------------------------------------
// first_fit_hour_slot_allocator_core
// First-fit allocator of hour intervals to vehicles, one cell per vehicle.
// ----------------------------------------------------------------------------
// Each request beat names an hour interval [start_hour, end_hour) and is
// granted to the lowest-numbered vehicle whose bitmap is free over it; an
// empty interval goes to vehicle 1, and a request no vehicle can take comes
// back refused with vehicle 0. A request with new_batch set clears every
// bitmap and the in-use count before it is served. The block handles one
// request at a time: the request walks a chain of MAX_VEHICLES cells, one
// cell per cycle unless the output stalls the chain, and the response beat is
// registered at its tail; the next request is taken the cycle after that
// response is registered, even while it still waits on the output.
// ----------------------------------------------------------------------------
module first_fit_hour_slot_allocator_core #(
  parameter int MAX_VEHICLES = 32,
  parameter int HOUR_SLOTS   = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fhs_req_if.sink   req_i,
  fhs_rsp_if.source rsp_o
);
  import fhs_pkg::*;

  localparam int EXT_W = 7;

  // Chain taps: index 0 is the launch register, index N is the tail
  fhs_tok_t              tok_chain  [MAX_VEHICLES+1];
  logic [HOUR_SLOTS-1:0] want_chain [MAX_VEHICLES+1];

  logic                  busy_q;
  logic                  launch_q;
  logic [HOUR_SLOTS-1:0] launch_want_q;
  logic [HOUR_SLOTS-1:0] want_d;
  logic [EXT_W-1:0]      end_clamp;
  logic                  accept;
  logic                  clr;
  logic                  en;
  logic                  capture;
  logic [CNT_W-1:0]      used_q;
  logic [CNT_W-1:0]      granted;
  logic                  out_valid_q;
  logic [VEH_W-1:0]      out_vehicle_q;
  logic [VEH_W-1:0]      out_used_q;
  logic                  out_refused_q;
  fhs_tok_t              tail;

  // Take a request only with the chain empty
  assign req_i.ready = !busy_q;
  assign accept      = req_i.valid && !busy_q;
  assign clr         = accept && req_i.new_batch;

  // Freeze the chain while a finished token cannot land in the output stage
  assign tail    = tok_chain[MAX_VEHICLES];
  assign en      = !(tail.active && out_valid_q && !rsp_o.ready);
  assign capture = tail.active && en;

  // Clamp the end hour to the slot count, then build the interval mask
  always_comb begin
    if (EXT_W'(req_i.end_hour) > EXT_W'(HOUR_SLOTS)) begin
      end_clamp = EXT_W'(HOUR_SLOTS);
    end else begin
      end_clamp = EXT_W'(req_i.end_hour);
    end
    for (int h = 0; h < HOUR_SLOTS; h++) begin
      want_d[h] = (EXT_W'(h) >= EXT_W'(req_i.start_hour)) && (EXT_W'(h) < end_clamp);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      launch_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (capture) begin
        busy_q <= 1'b0;
      end
      if (en) begin
        launch_q <= accept;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      launch_want_q <= want_d;
    end
  end

  always_comb begin
    tok_chain[0]        = '0;
    tok_chain[0].active = launch_q;
    want_chain[0]       = launch_want_q;
  end

  // One cell per vehicle, vehicle v+1 in cell v
  for (genvar v = 0; v < MAX_VEHICLES; v++) begin : g_cell
    fhs_cell #(
      .HOUR_SLOTS (HOUR_SLOTS),
      .CELL_IDX   (v)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .clr_i  (clr),
      .tok_i  (tok_chain[v]),
      .want_i (want_chain[v]),
      .tok_o  (tok_chain[v+1]),
      .want_o (want_chain[v+1])
    );
  end

  // Vehicle number of the tail token, zero when nobody took it
  assign granted = tail.hit ? (CNT_W'(tail.idx) + CNT_W'(1)) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (clr) begin
        used_q <= '0;
      end else if (capture && (granted > used_q)) begin
        used_q <= granted;
      end
      if (capture) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Register the response beat; the count reflects this grant
  always_ff @(posedge clk_i) begin
    if (capture) begin
      out_vehicle_q <= granted[VEH_W-1:0];
      out_refused_q <= !tail.hit;
      if (granted > used_q) begin
        out_used_q <= granted[VEH_W-1:0];
      end else begin
        out_used_q <= used_q[VEH_W-1:0];
      end
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.vehicle         = out_vehicle_q;
  assign rsp_o.vehicles_in_use = out_used_q;
  assign rsp_o.refused         = out_refused_q;

endmodule

/* rtl/fhs_cell.sv */
// ----------------------------------------------------------------------------
// fhs_cell
// One vehicle: holds its hour bitmap and claims a passing request if free.
// ----------------------------------------------------------------------------
module fhs_cell #(
  parameter int HOUR_SLOTS = 24,
  parameter int CELL_IDX   = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  clr_i,
  input  fhs_pkg::fhs_tok_t     tok_i,
  input  logic [HOUR_SLOTS-1:0] want_i,
  output fhs_pkg::fhs_tok_t     tok_o,
  output logic [HOUR_SLOTS-1:0] want_o
);
  import fhs_pkg::*;

  logic [HOUR_SLOTS-1:0] occ_q, occ_d;
  fhs_tok_t              tok_q, tok_d;
  logic [HOUR_SLOTS-1:0] want_q;
  logic                  take;

  // Claim only the first free vehicle along the chain
  assign take = en_i && tok_i.active && !tok_i.hit && ((occ_q & want_i) == '0);

  always_comb begin
    tok_d = tok_i;
    if (take) begin
      tok_d.hit = 1'b1;
      tok_d.idx = IDX_W'(CELL_IDX);
    end
  end

  always_comb begin
    occ_d = occ_q;
    if (clr_i) begin
      occ_d = '0;
    end else if (take) begin
      occ_d = occ_q | want_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      tok_q <= '0;
    end else begin
      occ_q <= occ_d;
      if (en_i) begin
        tok_q <= tok_d;
      end
    end
  end

  // Pass the mask along with the token, hold it during a stall
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      want_q <= want_i;
    end
  end

  assign tok_o  = tok_q;
  assign want_o = want_q;

endmodule

/* tb/first_fit_hour_slot_allocator_core_tb.sv */
// ----------------------------------------------------------------------------
// first_fit_hour_slot_allocator_core_tb
// Self-checking bench for the first-fit hour-slot allocator.
// ----------------------------------------------------------------------------
// Booking requests go in on the request channel. A scoreboard keeps its own
// copy of every vehicle's hour bitmap and of the in-use count, and it works out
// the grant each accepted request must produce. Response beats are checked in
// order against those grants. The stimulus starts with a directed pass over
// the edge cases: full day, empty and inverted intervals, hours past the last
// slot, and batch clears. It then runs random batches of three kinds:
// sorted bookings, crowded batches that overrun the fleet and get refused, and
// raw noise. Both channels idle in random bursts. Once, the receiver holds off
// for a long stretch so that the block backs up onto its input. The last part
// runs with no idling at all.
// ----------------------------------------------------------------------------
module first_fit_hour_slot_allocator_core_tb;
  import fhs_pkg::*;

  localparam int FLEET      = 32;
  localparam int SLOTS      = 24;
  localparam int LONG_HOLD  = 400;         // cycles the receiver stays closed once
  localparam int DRAIN      = FLEET + 16;  // settle time after the last grant
  localparam int TIMEOUT    = 5_000_000;   // time units, far past the slowest run
  localparam int MAX_REPORT = 10;

  typedef struct packed {
    logic [VEH_W-1:0] vehicle;
    logic [VEH_W-1:0] in_use;
    logic             refused;
  } grant_t;

  // --------------------------------------------------------------------------
  // Scoreboard: fleet bitmaps, high-water count and the grants still owed
  // --------------------------------------------------------------------------
  class fleet_scoreboard;
    logic [SLOTS-1:0] busy_hours [FLEET];
    int unsigned      fleet_size;
    grant_t           grants_due [$];
    int unsigned      failures;

    function new();
      clear_fleet();
      failures = 0;
    endfunction

    function void clear_fleet();
      for (int v = 0; v < FLEET; v++) busy_hours[v] = '0;
      fleet_size = 0;
    endfunction

    // Work out the grant for one accepted request and advance the fleet state.
    function void note_request(logic [HOUR_W-1:0] first_hour,
                               logic [HOUR_W-1:0] stop_hour, logic new_batch);
      logic [SLOTS-1:0] want;
      int unsigned      stop_clamped;
      int unsigned      winner;
      grant_t           g;
      if (new_batch) clear_fleet();
      // Clamp the end to the last slot; an inverted interval stays empty.
      stop_clamped = (stop_hour > SLOTS) ? SLOTS : stop_hour;
      want = '0;
      for (int h = 0; h < SLOTS; h++)
        if (h >= first_hour && h < stop_clamped) want[h] = 1'b1;
      // Scan vehicles from 1 upward; the first one free over the interval wins.
      winner = 0;
      for (int v = 0; v < FLEET; v++) begin
        if ((busy_hours[v] & want) == '0) begin
          winner = v + 1;
          busy_hours[v] |= want;
          break;
        end
      end
      if (winner > fleet_size) fleet_size = winner;
      g.vehicle = VEH_W'(winner);
      g.in_use  = VEH_W'(fleet_size);
      g.refused = (winner == 0);
      grants_due.push_back(g);
    endfunction

    // Compare one response beat with the oldest grant owed.
    function void check_grant(grant_t got);
      grant_t want;
      if (grants_due.size() == 0) begin
        if (failures < MAX_REPORT)
          $display("[%0t] unexpected grant: vehicle=%0d in_use=%0d refused=%0b",
                   $time, got.vehicle, got.in_use, got.refused);
        failures++;
        return;
      end
      want = grants_due.pop_front();
      if (got.vehicle !== want.vehicle || got.in_use !== want.in_use ||
          got.refused !== want.refused) begin
        if (failures < MAX_REPORT)
          $display("[%0t] mismatch (exp/got): vehicle %0d/%0d, in_use %0d/%0d, refused %0b/%0b",
                   $time, want.vehicle, got.vehicle, want.in_use, got.in_use,
                   want.refused, got.refused);
        failures++;
      end
    endfunction

    function int unsigned grants_outstanding();
      return grants_due.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  fhs_req_if req ();
  fhs_rsp_if rsp ();

  first_fit_hour_slot_allocator_core #(
    .MAX_VEHICLES (FLEET),
    .HOUR_SLOTS   (SLOTS)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  fleet_scoreboard sb = new();

  bit          idle_on       = 1'b1;  // random idle bursts on both channels
  int unsigned hold_requests = 0;     // bump to ask the receiver for a long hold
  int unsigned requests_sent = 0;

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Offer one request and hold it until the block takes the beat. Drop valid
  // only when an idle burst follows, so back-to-back beats never toggle it.
  task automatic send_request(input logic [HOUR_W-1:0] first_hour,
                              input logic [HOUR_W-1:0] stop_hour,
                              input logic new_batch);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid      <= 1'b1;
    req.start_hour <= first_hour;
    req.end_hour   <= stop_hour;
    req.new_batch  <= new_batch;
    do @(posedge clk_i); while (!req.ready);
    sb.note_request(first_hour, stop_hour, new_batch);
    requests_sent++;
  endtask

  // Random batches until `count` more requests have gone in. Most batches are
  // well-formed bookings in start order; crowded batches pile every request on
  // one hour so the fleet runs out; noise uses any field values at all.
  task automatic send_random_batches(input int unsigned count);
    int unsigned goal;
    int unsigned kind;
    int unsigned n;
    int unsigned cur;
    int unsigned stop;
    int unsigned pin;
    goal = requests_sent + count;
    while (requests_sent < goal) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        n   = $urandom_range(1, 40);
        cur = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
          cur  = cur + $urandom_range(0, 2);
          if (cur > SLOTS - 1) cur = SLOTS - 1;
          stop = cur + $urandom_range(1, 10);
          if (stop > 31) stop = 31;
          send_request(HOUR_W'(cur), HOUR_W'(stop), i == 0);
        end
      end else if (kind <= 7) begin
        n   = $urandom_range(FLEET + 1, FLEET + 8);
        pin = $urandom_range(0, SLOTS - 1);
        for (int i = 0; i < n; i++)
          send_request(HOUR_W'($urandom_range(0, pin)),
                       HOUR_W'($urandom_range(pin + 1, 31)), i == 0);
      end else begin
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++)
          send_request(HOUR_W'($urandom_range(0, 31)), HOUR_W'($urandom_range(0, 31)),
                       $urandom_range(0, 7) == 0);
      end
    end
  endtask

  initial begin : request_source
    req.valid      <= 1'b0;
    req.start_hour <= '0;
    req.end_hour   <= '0;
    req.new_batch  <= 1'b0;
    rst_ni         <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: full day twice, empty and inverted intervals, start past the
    // last slot, end clamped to the last slot, batch clears mid-stream.
    send_request(5'd0,  5'd24, 1'b1);
    send_request(5'd0,  5'd24, 1'b0);
    send_request(5'd0,  5'd0,  1'b0);
    send_request(5'd10, 5'd3,  1'b0);
    send_request(5'd24, 5'd31, 1'b0);
    send_request(5'd31, 5'd31, 1'b0);
    send_request(5'd5,  5'd31, 1'b0);
    send_request(5'd23, 5'd24, 1'b0);
    send_request(5'd0,  5'd1,  1'b1);
    send_request(5'd1,  5'd2,  1'b0);
    send_request(5'd0,  5'd24, 1'b0);
    send_request(5'd21, 5'd30, 1'b0);
    send_request(5'd16, 5'd16, 1'b1);
    send_request(5'd31, 5'd0,  1'b0);
    send_request(5'd15, 5'd17, 1'b0);
    send_request(5'd8,  5'd25, 1'b0);
    send_request(5'd16, 5'd24, 1'b0);
    send_request(5'd7,  5'd15, 1'b1);

    send_random_batches(400);

    // Close the receiver for a long stretch and keep offering requests, so
    // the block fills and stalls its input.
    hold_requests++;
    send_random_batches(380);

    // Last part: no idling on either side.
    idle_on = 1'b0;
    send_random_batches(150);
    req.valid <= 1'b0;

    // Wait for every owed grant, then give the block time to show any extra.
    while (sb.grants_outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (sb.failures == 0 && sb.grants_outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Response side: sample beats at the edge, then pick next cycle's ready
  // --------------------------------------------------------------------------
  initial begin : grant_sink
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned holds_seen;
    grant_t      got;
    stall_left = 0;
    hold_left  = 0;
    holds_seen = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp.valid && rsp.ready) begin
        got.vehicle = rsp.vehicle;
        got.in_use  = rsp.vehicles_in_use;
        got.refused = rsp.refused;
        sb.check_grant(got);
      end
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #(TIMEOUT);
    $display("status: fail");
    $finish;
  end

endmodule
